### hdl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants for the battery charge trend and percent block.
// ----------------------------------------------------------------------------
`default_nettype none

package bct_pkg;

    // default millivolt width
    localparam int MV_BITS_DEF = 13;

    localparam int THR_W  = 10;
    localparam int LEN_W  = 4;
    localparam int CNT_W  = 4;
    localparam int PCT_W  = 7;
    localparam int STEP_W = 3;
    localparam int IDX_W  = 3;

    // quotient bits from the divider (percent is below 128)
    localparam int QUO_STEPS = PCT_W;

    // index of the first (most significant) division step
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_STEPS - 1);

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [CNT_W-1:0] CNT_MAX  = 4'd15;

    // register reset values
    localparam logic [THR_W-1:0] THR_RST   = 10'd5;
    localparam logic [LEN_W-1:0] RISE_RST  = 4'd3;
    localparam logic [LEN_W-1:0] FALL_RST  = 4'd3;
    localparam int               EMPTY_RST = 3300;
    localparam int               FULL_RST  = 4200;

    // register indexes
    localparam logic [IDX_W-1:0] REG_STEP_THR  = 3'd0;
    localparam logic [IDX_W-1:0] REG_RISE_LEN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FALL_LEN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_EMPTY_MV  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FULL_MV   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic              load;     // take the sample, update the trend
        logic              prep;     // form numerator, divisor, clamps
        logic              step;     // one restoring division step
        logic [STEP_W-1:0] step_idx; // quotient bit of this step
        logic              push;     // move the result into the output register
    } t_cmd;

endpackage

`default_nettype wire

### hdl/bct_ctrl.sv
// ----------------------------------------------------------------------------
// bct_ctrl
// Sequencer: accept, prepare, seven division steps, hand the result over to
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_cfg_ready,
    output bct_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [bct_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        r_out_valid, n_out_valid;
    logic                        w_push;

    // finished result moves out when the output register is free or leaving
    assign w_push = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (w_push)                  n_out_valid = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = S_DIV;
                n_step  = bct_pkg::STEP_LAST;
            end
            S_DIV: begin
                if (r_step == '0) n_state = S_DONE;
                else              n_step  = r_step - 1'b1;
            end
            S_DONE: begin
                if (w_push) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.step     = (r_state == S_DIV);
        o_cmd.step_idx = r_step;
        o_cmd.push     = w_push;
    end

endmodule

`default_nettype wire

### hdl/bct_dp.sv
// ----------------------------------------------------------------------------
// bct_dp
// Datapath: config registers, trend tracking, restoring percent divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_dp #(
    parameter int MV_BITS = bct_pkg::MV_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bct_pkg::t_cmd               i_cmd,
    input  wire logic                        i_cfg_we,
    input  wire logic [bct_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [MV_BITS-1:0]          i_cfg_data,
    input  wire logic [MV_BITS-1:0]          i_sample_mv,
    output logic      [bct_pkg::PCT_W-1:0]   o_percent,
    output logic                             o_charging
);

    localparam int MV1   = MV_BITS + 1;
    localparam int NUM_W = MV_BITS + bct_pkg::PCT_W;

    // config
    logic [bct_pkg::THR_W-1:0] r_thr;
    logic [bct_pkg::LEN_W-1:0] r_rise_len, r_fall_len;
    logic [MV_BITS-1:0]        r_empty, r_full;

    // trend state
    logic                      r_have_prev;
    logic [MV_BITS-1:0]        r_prev;
    logic [bct_pkg::CNT_W-1:0] r_rise_cnt, r_fall_cnt;
    logic                      r_flag;

    // division
    logic [MV_BITS-1:0]        r_sample;
    logic [NUM_W-1:0]          r_rem;
    logic [MV_BITS-1:0]        r_den;
    logic [bct_pkg::PCT_W-1:0] r_quot;
    logic                      r_lo, r_hi;

    // result
    logic [bct_pkg::PCT_W-1:0] w_percent;
    logic [bct_pkg::PCT_W-1:0] r_out_percent;
    logic                      r_out_charging;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= bct_pkg::THR_RST;
            r_rise_len <= bct_pkg::RISE_RST;
            r_fall_len <= bct_pkg::FALL_RST;
            r_empty    <= MV_BITS'(bct_pkg::EMPTY_RST);
            r_full     <= MV_BITS'(bct_pkg::FULL_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bct_pkg::REG_STEP_THR: r_thr      <= i_cfg_data[bct_pkg::THR_W-1:0];
                bct_pkg::REG_RISE_LEN: r_rise_len <= i_cfg_data[bct_pkg::LEN_W-1:0];
                bct_pkg::REG_FALL_LEN: r_fall_len <= i_cfg_data[bct_pkg::LEN_W-1:0];
                bct_pkg::REG_EMPTY_MV: r_empty    <= i_cfg_data;
                bct_pkg::REG_FULL_MV:  r_full     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // trend decision on the incoming sample
    logic [MV1-1:0]            w_prev_up, w_samp_up;
    logic                      w_rise, w_fall;
    logic [bct_pkg::CNT_W-1:0] w_rise_inc, w_fall_inc;

    always_comb begin
        w_prev_up  = MV1'(r_prev) + MV1'(r_thr);
        w_samp_up  = MV1'(i_sample_mv) + MV1'(r_thr);
        w_rise     = MV1'(i_sample_mv) > w_prev_up;
        w_fall     = w_samp_up < MV1'(r_prev);
        w_rise_inc = (r_rise_cnt == bct_pkg::CNT_MAX) ? r_rise_cnt : r_rise_cnt + 1'b1;
        w_fall_inc = (r_fall_cnt == bct_pkg::CNT_MAX) ? r_fall_cnt : r_fall_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_rise_cnt  <= '0;
            r_fall_cnt  <= '0;
            r_flag      <= 1'b0;
        end else if (i_cmd.load) begin
            r_have_prev <= 1'b1;
            r_prev      <= i_sample_mv;
            if (r_have_prev) begin
                priority if (w_rise) begin
                    r_rise_cnt <= w_rise_inc;
                    r_fall_cnt <= '0;
                    if (w_rise_inc >= r_rise_len) r_flag <= 1'b1;
                end else if (w_fall) begin
                    r_fall_cnt <= w_fall_inc;
                    r_rise_cnt <= '0;
                    if (w_fall_inc >= r_fall_len) r_flag <= 1'b0;
                end else begin
                    r_rise_cnt <= '0;
                    r_fall_cnt <= '0;
                end
            end
        end
    end

    // divider: quotient bit per step, remainder starts as (mv-empty)*100
    logic [MV_BITS-1:0] w_diff;
    logic [NUM_W-1:0]   w_num, w_trial;

    always_comb begin
        w_diff  = r_sample - r_empty;
        w_num   = NUM_W'(w_diff) * NUM_W'(bct_pkg::PCT_FULL);
        w_trial = NUM_W'(r_den) << i_cmd.step_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_sample <= i_sample_mv;
        if (i_cmd.prep) begin
            r_rem  <= w_num;
            r_den  <= r_full - r_empty;
            r_quot <= '0;
            r_lo   <= (r_sample <= r_empty);
            r_hi   <= (r_sample >= r_full);
        end else if (i_cmd.step) begin
            if (r_rem >= w_trial) begin
                r_rem                   <= r_rem - w_trial;
                r_quot[i_cmd.step_idx]  <= 1'b1;
            end
        end
    end

    always_comb begin
        priority if (r_lo) w_percent = '0;
        else if (r_hi)     w_percent = bct_pkg::PCT_FULL;
        else               w_percent = r_quot;
    end

    // output register: holds a finished result while the next item runs
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_percent  <= w_percent;
            r_out_charging <= r_flag;
        end
    end

    assign o_percent  = r_out_percent;
    assign o_charging = r_out_charging;

endmodule

`default_nettype wire

### hdl/battery_charge_trend_and_percent.sv
// ----------------------------------------------------------------------------
// battery_charge_trend_and_percent
// Tracks rising/falling voltage streaks into a sticky charging flag and
// turns each sample into a whole-number charge percentage.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  sample   | in        | i_valid / o_stall          | i_sample_mv
//  result   | out       | o_valid / i_stall          | o_percent, o_charging
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Accept, a prepare state, seven restoring divide steps (one quotient bit
//  each), then a done state that loads the output register; the shared
//  divider loop finishes one sample before it accepts the next one.
//  A stalled result waits in the output register while the next item runs;
//  the input is stalled whenever the block is not idle. Sync active-low reset
//  loads default registers, clears trend state; config taken only when empty.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_trend_and_percent #(
    parameter int MV_BITS = bct_pkg::MV_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // sample in
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [MV_BITS-1:0]         i_sample_mv,
    // result out
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [bct_pkg::PCT_W-1:0]       o_percent,
    output logic                            o_charging,
    // config writes
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [bct_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [MV_BITS-1:0]         i_cfg_data
);

    bct_pkg::t_cmd w_cmd;

    // sequencer
    bct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    // trend tracking, registers, divider and output register
    bct_dp #(
        .MV_BITS (MV_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample_mv (i_sample_mv),
        .o_percent   (o_percent),
        .o_charging  (o_charging)
    );

endmodule

`default_nettype wire
